/* rtl/core/dqir_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqir_pkg: shared types and codes for the deque with indexed removal
// Operation and status codes, field widths, the entry record and the
// per-cell control record.
// ----------------------------------------------------------------------------
package dqir_pkg;

  localparam int ID_W  = 16;
  localparam int POS_W = 4;
  localparam int OCC_W = 5;
  localparam int OP_W  = 2;
  localparam int ST_W  = 2;

  localparam logic [OP_W-1:0] OP_APPEND    = 2'd0;
  localparam logic [OP_W-1:0] OP_TAKE_HEAD = 2'd1;
  localparam logic [OP_W-1:0] OP_TAKE_TAIL = 2'd2;
  localparam logic [OP_W-1:0] OP_TAKE_POS  = 2'd3;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

  // tdata widths, padded to whole bytes
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;

  typedef struct packed {
    logic [ID_W-1:0] client;
    logic [ID_W-1:0] cart;
  } entry_t;

  typedef struct packed {
    logic load;   // take the appended entry
    logic shift;  // take the right neighbor's entry
    logic tap;    // present own entry as the removed one
  } cell_ctrl_t;

endpackage

/* rtl/core/dqir_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqir_cell: one entry slot of the deque
// Holds one entry; loads an appended entry, takes its right neighbor's entry
// when the row closes a gap, and drives its entry onto the take bus.
// ----------------------------------------------------------------------------
module dqir_cell (
  input  logic                clk,
  input  dqir_pkg::cell_ctrl_t ctrl,
  input  dqir_pkg::entry_t    append_entry,
  input  dqir_pkg::entry_t    right_entry,
  output dqir_pkg::entry_t    cur_entry,
  output dqir_pkg::entry_t    tap_entry
);
  import dqir_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;

  always_comb begin
    priority if (ctrl.load) begin
      entry_nxt = append_entry;
    end else if (ctrl.shift) begin
      entry_nxt = right_entry;
    end else begin
      entry_nxt = entry_r;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign cur_entry = entry_r;
  assign tap_entry = ctrl.tap ? entry_r : '0;

endmodule

/* rtl/core/deque_with_indexed_removal.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_with_indexed_removal: bounded deque with removal at an index
// A row of DEPTH entry cells, head in cell 0, closing gaps by a parallel
// one-place shift toward the head.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  channel: one operation per transfer (append, take head, take tail,
//         take at position). in_tdata packs op, client_id, cart_id, position.
//   out_* channel: one result per operation: status, taken entry (zero when
//         nothing is removed) and the occupancy after the operation.
//   Result: the result appears in the cycle after the input transfer, from the
//   output register.
//   Throughput: one operation per cycle while out_tready is high; every cell
//   updates in the same cycle, so the whole row shifts at once.
//   Reset: the occupancy returns to zero; the cell contents are not cleared
//   and are never read before they are written.
//   Stall: while a result waits and out_tready is low, in_tready is low and
//   the result is held; taking the result frees the block in the same cycle.
// ----------------------------------------------------------------------------
module deque_with_indexed_removal #(
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [1:0] op, [17:2] client_id, [33:18] cart_id, [37:34] position
  input  logic [dqir_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [1:0] status, [17:2] taken_client, [33:18] taken_cart, [38:34] occupancy
  output logic [dqir_pkg::OUT_DATA_W-1:0] out_tdata
);
  import dqir_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  logic [CNT_W-1:0]      count_r;
  logic [CNT_W-1:0]      count_nxt;
  logic                  out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;

  logic [OP_W-1:0]  op;
  logic [POS_W-1:0] position;
  entry_t           append_entry;

  logic             fire;
  logic             full;
  logic             empty;
  logic [ST_W-1:0]  status;
  logic             do_append;
  logic             do_remove;
  logic [CMP_W-1:0] rm_idx;
  logic [CMP_W-1:0] cnt_ext;
  entry_t           taken;

  cell_ctrl_t ctrl     [DEPTH];
  entry_t     cur_ent  [DEPTH];
  entry_t     tap_ent  [DEPTH];
  entry_t     right_ent[DEPTH];

  assign op                  = in_tdata[1:0];
  assign append_entry.client = in_tdata[17:2];
  assign append_entry.cart   = in_tdata[33:18];
  assign position            = in_tdata[37:34];

  assign in_tready = !out_tvalid_r || out_tready;
  assign fire      = in_tvalid && in_tready;
  assign full      = (count_r == CNT_W'(DEPTH));
  assign empty     = (count_r == '0);
  assign cnt_ext   = CMP_W'(count_r);

  always_comb begin
    status    = ST_OK;
    do_append = 1'b0;
    do_remove = 1'b0;
    rm_idx    = '0;
    priority if (op == OP_APPEND) begin
      if (full) begin
        status = ST_FULL;
      end else begin
        do_append = 1'b1;
      end
    end else if (empty) begin
      status = ST_EMPTY;
    end else begin
      unique case (op)
        OP_TAKE_HEAD: begin
          do_remove = 1'b1;
        end
        OP_TAKE_TAIL: begin
          do_remove = 1'b1;
          rm_idx    = CMP_W'(count_r - CNT_W'(1));
        end
        default: begin
          if (CMP_W'(position) >= cnt_ext) begin
            status = ST_RANGE;
          end else begin
            do_remove = 1'b1;
            rm_idx    = CMP_W'(position);
          end
        end
      endcase
    end
  end

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      if (g == DEPTH - 1) begin : g_last
        assign right_ent[g] = cur_ent[g];
      end else begin : g_mid
        assign right_ent[g] = cur_ent[g+1];
      end

      assign ctrl[g].load  = fire && do_append && (CMP_W'(g) == cnt_ext);
      assign ctrl[g].shift = fire && do_remove && (CMP_W'(g) >= rm_idx);
      assign ctrl[g].tap   = do_remove && (CMP_W'(g) == rm_idx);

      dqir_cell u_cell (
        .clk          (clk),
        .ctrl         (ctrl[g]),
        .append_entry (append_entry),
        .right_entry  (right_ent[g]),
        .cur_entry    (cur_ent[g]),
        .tap_entry    (tap_ent[g])
      );
    end
  endgenerate

  // OR the single tapped cell onto the take bus
  always_comb begin
    taken = '0;
    for (int i = 0; i < DEPTH; i++) begin
      taken = taken | tap_ent[i];
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (do_append) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_remove) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (fire) begin
        count_r <= count_nxt;
      end
      if (fire) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_tdata_r <= {1'b0, OCC_W'(count_nxt), taken.cart, taken.client, status};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

/* rtl/core/dqir_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqir_checker: port-level checks for the deque with indexed removal
// Watches the result channel for consistent status, taken entry and occupancy,
// for a held result while stalled, and for a result after each accepted input.
// ----------------------------------------------------------------------------
module dqir_checker #(
  parameter int DEPTH = 16
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [dqir_pkg::OUT_DATA_W-1:0] out_tdata
);
  import dqir_pkg::*;

  logic [ST_W-1:0]  st;
  logic [OCC_W-1:0] occ;
  logic             accepted;

  assign st       = out_tdata[1:0];
  assign occ      = out_tdata[38:34];
  assign accepted = in_tvalid && in_tready;

  // a failed operation removes nothing, so its taken entry is all zero
  a_taken_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (st != ST_OK) |-> (out_tdata[33:2] == '0))
    else $error("taken entry not zero on a failed operation");

  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (st == ST_FULL) |-> (occ == OCC_W'(DEPTH)))
    else $error("full status with occupancy below depth");

  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (st == ST_EMPTY) |-> (occ == '0))
    else $error("empty status with nonzero occupancy");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accepted |=> out_tvalid)
    else $error("no result after an accepted operation");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

endmodule

bind deque_with_indexed_removal dqir_checker #(.DEPTH(DEPTH)) u_dqir_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for deque_with_indexed_removal
// Streams append, take-head, take-tail and take-at-position operations into
// the block and scores every result against a behavioral copy of the store.
// The stimulus is a short directed list of corner cases, then 550 random
// operations in fill and drain runs. Both sides of the stream stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import dqir_pkg::*;

  localparam int DEPTH        = 16;
  localparam int RANDOM_OPS   = 550;
  localparam int STALL_LIMIT  = 2000;
  localparam int RESET_CYCLES = 11;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [ID_W-1:0]  client;
    logic [ID_W-1:0]  cart;
    logic [POS_W-1:0] position;
  } deque_op_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [ID_W-1:0]  client;
    logic [ID_W-1:0]  cart;
    logic [OCC_W-1:0] occupancy;
  } deque_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // [1:0] op, [17:2] client_id, [33:18] cart_id, [37:34] position
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // [1:0] status, [17:2] taken_client, [33:18] taken_cart, [38:34] occupancy
  logic [OUT_DATA_W-1:0] out_tdata;

  deque_op_t     pending_ops[$];
  deque_op_t     op_on_bus;
  entry_t        held_entries[$];
  deque_result_t expected_results[$];
  int            total_ops;
  int            ops_accepted;
  int            error_count;
  int            stall_cycles;
  int            mirror_count;

  deque_with_indexed_removal #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Apply one operation to the behavioral store and return its result.
  function automatic deque_result_t apply_operation(deque_op_t item);
    deque_result_t res;
    entry_t        ent;
    int            slot;
    res = '0;
    if (item.op == OP_APPEND) begin
      if (held_entries.size() >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        ent.client = item.client;
        ent.cart   = item.cart;
        held_entries.push_back(ent);
      end
    end else if (held_entries.size() == 0) begin
      res.status = ST_EMPTY;
    end else if (item.op == OP_TAKE_POS && item.position >= held_entries.size()) begin
      res.status = ST_RANGE;
    end else begin
      case (item.op)
        OP_TAKE_HEAD: slot = 0;
        OP_TAKE_TAIL: slot = held_entries.size() - 1;
        default:      slot = int'(item.position);
      endcase
      ent = held_entries[slot];
      held_entries.delete(slot);
      res.client = ent.client;
      res.cart   = ent.cart;
    end
    res.occupancy = OCC_W'(held_entries.size());
    return res;
  endfunction

  // Queue one operation and track the occupancy the generator expects.
  task automatic queue_op(logic [OP_W-1:0] op, logic [ID_W-1:0] client,
                          logic [ID_W-1:0] cart, logic [POS_W-1:0] position);
    deque_op_t item;
    item.op       = op;
    item.client   = client;
    item.cart     = cart;
    item.position = position;
    pending_ops.push_back(item);
    if (op == OP_APPEND) begin
      if (mirror_count < DEPTH) mirror_count++;
    end else if (mirror_count > 0) begin
      if (op != OP_TAKE_POS || position < mirror_count) mirror_count--;
    end
  endtask

  function automatic logic [ID_W-1:0] random_id();
    int pick;
    pick = $urandom_range(19);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return ID_W'($urandom_range(16'hFFFF));
  endfunction

  function automatic int sender_idle_pct();
    if (ops_accepted < total_ops / 3) return 6;
    if (ops_accepted < 2 * total_ops / 3) return 48;
    return 0;
  endfunction

  function automatic int receiver_idle_pct();
    if (ops_accepted < total_ops / 3) return 48;
    if (ops_accepted < 2 * total_ops / 3) return 6;
    return 0;
  endfunction

  task automatic report_field(string name, int unsigned exp_val, int unsigned got_val);
    if (exp_val != got_val) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, got_val);
      error_count++;
    end
  endtask

  // Driver: predict on each transfer, then present the next operation.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_results.push_back(apply_operation(op_on_bus));
        ops_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_ops.size() > 0 && $urandom_range(99) >= sender_idle_pct()) begin
          op_on_bus = pending_ops.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {2'b00, op_on_bus.position, op_on_bus.cart,
                        op_on_bus.client, op_on_bus.op};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: score each result transfer against the oldest expectation.
  always @(posedge clk) begin : monitor
    deque_result_t got;
    deque_result_t exp_res;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.status    = out_tdata[1:0];
        got.client    = out_tdata[17:2];
        got.cart      = out_tdata[33:18];
        got.occupancy = out_tdata[38:34];
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
          error_count++;
        end else begin
          exp_res = expected_results.pop_front();
          report_field("status", 32'(exp_res.status), 32'(got.status));
          report_field("taken_client", 32'(exp_res.client), 32'(got.client));
          report_field("taken_cart", 32'(exp_res.cart), 32'(got.cart));
          report_field("occupancy", 32'(exp_res.occupancy), 32'(got.occupancy));
        end
      end
      out_tready <= ($urandom_range(99) >= receiver_idle_pct());
    end
  end

  // Watchdog: stop when no transfer happens on either side for too long.
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end else if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int  pick;
    bit  filling;
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] position;

    ops_accepted = 0;
    error_count  = 0;
    mirror_count = 0;

    // Every take on an empty store; empty wins over a bad position.
    queue_op(OP_TAKE_HEAD, 16'h1234, 16'h5678, 4'd0);
    queue_op(OP_TAKE_TAIL, 16'hFFFF, 16'hFFFF, 4'd15);
    queue_op(OP_TAKE_POS, 16'h0000, 16'h0000, 4'd15);
    // Two entries at the field extremes, then a position equal to the count.
    queue_op(OP_APPEND, 16'h0000, 16'h0000, 4'd0);
    queue_op(OP_APPEND, 16'hFFFF, 16'hFFFF, 4'd15);
    queue_op(OP_TAKE_POS, 16'h0000, 16'h0000, 4'd2);
    // Take the tail by position, then the only entry by position.
    queue_op(OP_TAKE_POS, 16'h0000, 16'h0000, 4'd1);
    queue_op(OP_TAKE_POS, 16'h0000, 16'h0000, 4'd0);
    // Fill up, overflow once, then take the last slot by position.
    for (int i = 0; i < DEPTH; i++) begin
      queue_op(OP_APPEND, ID_W'(16'hA000 + i), ID_W'(16'h0C00 + i), POS_W'(i));
    end
    queue_op(OP_APPEND, 16'hDEAD, 16'hBEEF, 4'd0);
    queue_op(OP_TAKE_POS, 16'h0000, 16'h0000, 4'd15);

    // Random fill and drain runs; a few items are pure noise.
    filling = 1'b1;
    for (int n = 0; n < RANDOM_OPS; n++) begin
      pick     = $urandom_range(99);
      position = POS_W'($urandom_range(15));
      if (pick < 5) begin
        op = OP_W'($urandom_range(3));
      end else if ((filling && pick < 75) || (!filling && pick < 25)) begin
        op = OP_APPEND;
      end else begin
        op = OP_W'($urandom_range(OP_TAKE_HEAD, OP_TAKE_POS));
        if (op == OP_TAKE_POS && mirror_count > 0 && $urandom_range(99) < 85) begin
          position = POS_W'($urandom_range(mirror_count - 1));
        end
      end
      queue_op(op, random_id(), random_id(), position);
      if (mirror_count == DEPTH) filling = 1'b0;
      else if (mirror_count == 0) filling = 1'b1;
      else if ($urandom_range(99) < 3) filling = !filling;
    end
    total_ops = pending_ops.size();

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (pending_ops.size() > 0 || in_tvalid || expected_results.size() > 0);
    repeat (8) @(negedge clk);

    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/dqir_pkg.sv
rtl/core/dqir_cell.sv
rtl/core/deque_with_indexed_removal.sv
rtl/core/dqir_checker.sv
dv/testbench.sv
